/* rtl/assert_macros.svh */
// assertion helper macros for the sm3 engine checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked from reset onward
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sm3_pkg.sv */
// ---------------------------------------------------------------------------
// sm3 package
// shared constants, types and round functions of the sm3 hash engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sm3_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned DigestWords = 8;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds = 64;

  localparam logic [31:0] TLow  = 32'h79CC4519;
  localparam logic [31:0] THigh = 32'h7A879D8A;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t Iv [DigestWords] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  // start / done handshake between control and compression core
  typedef struct packed {
    logic start;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

/* rtl/sm3_hash_engine.sv */
// ---------------------------------------------------------------------------
// sm3 hash engine
// streaming sm3 hash over big-endian 32-bit words, 256-bit digest output
// ---------------------------------------------------------------------------
// Words are taken while the 64-byte block is filling. When a block fills,
// the compression core runs one round per cycle: a start step, 64 rounds
// and a done step, then a fold of the result into the chaining value, and
// in_ready stays low from the word that fills the block until the fold is
// done. Bytes of that word past the block end go into the new block during
// the fold. A final word adds padding one byte per cycle (plus a second
// compression when the length does not fit), then the eight digest words
// leave one per transfer on the out_ channel, after which the engine is back
// at the initial value. The engine takes no new word while the single round
// unit compresses a block.
`timescale 1ns / 1ps

module sm3_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_final_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_digest_index,
  output logic        out_digest_last
);

  sm3_pkg::state_t    state_r, state_nxt;
  sm3_pkg::word_t     blk_r [sm3_pkg::BlockWords];
  sm3_pkg::word_t     blk_nxt [sm3_pkg::BlockWords];
  sm3_pkg::word_t     cv_r [sm3_pkg::DigestWords];
  sm3_pkg::word_t     cv_new [sm3_pkg::DigestWords];
  logic [5:0]         pos_r;
  logic [63:0]        len_r;
  logic [2:0]         oidx_r;
  logic               fin_r;   // compression belongs to padding
  logic [31:0]        carry_r; // bytes of the filling word past the block end
  sm3_pkg::core_ctl_t core_ctl;
  sm3_pkg::core_sts_t core_sts;

  // pad phase marker: 0 means the 0x80 byte is still due, 1 afterward
  logic pad80_r;
  logic lenblk_r;   // padding block holds the length

  logic [2:0]  nb;
  logic [6:0]  pos_sum;
  logic [5:0]  fit;
  logic [6:0]  wr_pos;
  logic        accept;
  logic [63:0] bits;
  logic [7:0]  pad_byte;

  assign nb      = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
  assign pos_sum = {1'b0, pos_r} + {4'd0, nb};
  assign fit     = 6'd0 - pos_r;
  assign accept  = in_valid && in_ready;
  assign bits    = len_r << 3;

  sm3_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (core_ctl),
    .blk    (blk_r),
    .cv_in  (cv_r),
    .cv_out (cv_new),
    .sts    (core_sts)
  );

  // padding byte for the current position
  always_comb begin
    if (!pad80_r) pad_byte = sm3_pkg::PadByte;
    else if (lenblk_r && pos_r >= 6'd56) pad_byte = 8'(bits >> {6'd63 - pos_r, 3'd0});
    else pad_byte = 8'h00;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sm3_pkg::ST_IDLE: begin
        if (accept) begin
          if (pos_sum[6]) state_nxt = sm3_pkg::ST_ROUND;
          else if (in_final_word) state_nxt = sm3_pkg::ST_PAD;
        end
      end
      sm3_pkg::ST_ROUND: if (core_sts.done) state_nxt = sm3_pkg::ST_FOLD;
      sm3_pkg::ST_FOLD: begin
        if (!fin_r) state_nxt = sm3_pkg::ST_IDLE;
        else if (lenblk_r) state_nxt = sm3_pkg::ST_OUT;
        else state_nxt = sm3_pkg::ST_PAD;
      end
      sm3_pkg::ST_PAD: if (pos_r == 6'd63) state_nxt = sm3_pkg::ST_ROUND;
      sm3_pkg::ST_OUT: if (out_ready && oidx_r == 3'd7) state_nxt = sm3_pkg::ST_IDLE;
      default: state_nxt = sm3_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state_r == sm3_pkg::ST_IDLE);
    out_valid = (state_r == sm3_pkg::ST_OUT);
    core_ctl.start = (state_r == sm3_pkg::ST_ROUND) && !core_sts.busy && !core_sts.done;
  end

  assign out_digest_word  = cv_r[oidx_r];
  assign out_digest_index = oidx_r;
  assign out_digest_last  = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sm3_pkg::ST_IDLE;
      pos_r   <= '0;
      len_r   <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      carry_r <= '0;
      pad80_r <= 1'b0;
      lenblk_r <= 1'b0;
      cv_r    <= sm3_pkg::Iv;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        sm3_pkg::ST_IDLE: begin
          if (accept) begin
            pos_r <= pos_sum[5:0];
            len_r <= len_r + 64'(nb);
            fin_r <= in_final_word;
            carry_r <= in_message_word << {fit[2:0], 3'd0};
            pad80_r <= 1'b0;
          end
        end
        sm3_pkg::ST_FOLD: begin
          cv_r <= cv_new;
          if (fin_r && lenblk_r) begin
            oidx_r   <= '0;
            lenblk_r <= 1'b0;
          end else if (fin_r) begin
            lenblk_r <= pad80_r;
          end
        end
        sm3_pkg::ST_PAD: begin
          pad80_r <= 1'b1;
          pos_r   <= pos_r + 6'd1;
          // length fits behind the 0x80 byte only below byte 56
          if (!pad80_r) lenblk_r <= (pos_r < 6'd56);
        end
        sm3_pkg::ST_OUT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              cv_r  <= sm3_pkg::Iv;
              len_r <= '0;
              pos_r <= '0;
              fin_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // block store update: message bytes, overflow bytes and padding bytes
  always_comb begin
    blk_nxt = blk_r;
    wr_pos  = '0;
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        wr_pos = {1'b0, pos_r} + 7'(i);
        if (3'(i) < nb && !wr_pos[6])
          blk_nxt[wr_pos[5:2]][(3 - wr_pos[1:0]) * 8 +: 8] = in_message_word[(3 - i) * 8 +: 8];
      end
    end else if (state_r == sm3_pkg::ST_FOLD) begin
      for (int i = 0; i < 3; i++) begin
        if (6'(i) < pos_r) blk_nxt[0][(3 - i) * 8 +: 8] = carry_r[(3 - i) * 8 +: 8];
      end
    end else if (state_r == sm3_pkg::ST_PAD) begin
      blk_nxt[pos_r[5:2]][(3 - pos_r[1:0]) * 8 +: 8] = pad_byte;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

/* rtl/sm3_core.sv */
// ---------------------------------------------------------------------------
// sm3 compression core
// one round per cycle over a 16-word sliding message schedule
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sm3_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sm3_pkg::core_ctl_t   ctl,
  input  sm3_pkg::word_t       blk [sm3_pkg::BlockWords],
  input  sm3_pkg::word_t       cv_in [sm3_pkg::DigestWords],
  output sm3_pkg::word_t       cv_out [sm3_pkg::DigestWords],
  output sm3_pkg::core_sts_t   sts
);

  sm3_pkg::word_t w_r [sm3_pkg::BlockWords];
  sm3_pkg::word_t v_r [sm3_pkg::DigestWords];
  logic [5:0]     rnd_r;
  logic           busy_r;
  logic           done_r;

  sm3_pkg::word_t t_j, a12, ss1, ss2, ff, gg, tt1, tt2, w_new;

  // round datapath
  always_comb begin
    t_j = (rnd_r < 6'd16) ? sm3_pkg::TLow : sm3_pkg::THigh;
    a12 = sm3_pkg::rotl(v_r[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + v_r[4] + sm3_pkg::rotl(t_j, rnd_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_r < 6'd16) begin
      ff = v_r[0] ^ v_r[1] ^ v_r[2];
      gg = v_r[4] ^ v_r[5] ^ v_r[6];
    end else begin
      ff = (v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]);
      gg = (v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]);
    end
    tt1 = ff + v_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2 = gg + v_r[7] + ss1 + w_r[0];
    // expansion of the word sixteen ahead
    w_new = sm3_pkg::perm1(w_r[0] ^ w_r[7] ^ sm3_pkg::rotl(w_r[13], 5'd15))
            ^ sm3_pkg::rotl(w_r[3], 5'd7) ^ w_r[10];
  end

  // round counter and status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'(sm3_pkg::Rounds - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // working registers and schedule window
  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r) begin
      w_r <= blk;
      v_r <= cv_in;
    end else if (busy_r) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      v_r[3] <= v_r[2];
      v_r[2] <= sm3_pkg::rotl(v_r[1], 5'd9);
      v_r[1] <= v_r[0];
      v_r[0] <= tt1;
      v_r[7] <= v_r[6];
      v_r[6] <= sm3_pkg::rotl(v_r[5], 5'd19);
      v_r[5] <= v_r[4];
      v_r[4] <= sm3_pkg::perm0(tt2);
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) cv_out[i] = cv_in[i] ^ v_r[i];
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* rtl/sm3_checker.sv */
// ---------------------------------------------------------------------------
// sm3 port checker
// watches the ports of the hash engine over time
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sm3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_digest_index,
  input logic        out_digest_last
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_digest_word), "digest dropped while stalled")
  `ASSERT_CLK(a_last_idx, clk, rst_n, out_valid |-> (out_digest_last == (out_digest_index == 3'd7)), "last flag off index")
  `ASSERT_CLK(a_no_overlap, clk, rst_n, out_valid |-> !in_ready, "input open during digest")
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "digest right after reset")

endmodule

bind sm3_hash_engine sm3_checker u_sm3_checker (.*);

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// sm3 hash engine testbench
// streams messages as big-endian words with random gaps and stalls, predicts
// each digest with an independent sm3 model and checks every digest word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected digest words and the hash state that produces them
class sm3_digest_board;
  sm3_pkg::word_t chain [8];
  sm3_pkg::word_t blk [16];
  logic [5:0] pos;
  logic [63:0] byte_cnt;
  sm3_pkg::word_t exp_word [$];
  logic [2:0] exp_index [$];
  logic exp_last [$];
  int errors;
  int digests;

  function new();
    errors = 0;
    digests = 0;
    restart();
  endfunction

  function void restart();
    foreach (chain[i]) chain[i] = sm3_pkg::Iv[i];
    foreach (blk[i]) blk[i] = '0;
    pos = '0;
    byte_cnt = '0;
  endfunction

  function sm3_pkg::word_t rol(sm3_pkg::word_t x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function void compress();
    sm3_pkg::word_t w [68];
    sm3_pkg::word_t r [8];
    sm3_pkg::word_t t, a12, ss1, ss2, ff, gg, tt1, tt2, p;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++) begin
      p = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
      w[j] = p ^ rol(p, 15) ^ rol(p, 23) ^ rol(w[j-13], 7) ^ w[j-6];
    end
    r = chain;
    for (int j = 0; j < 64; j++) begin
      t = (j < 16) ? sm3_pkg::TLow : sm3_pkg::THigh;
      a12 = rol(r[0], 12);
      ss1 = rol(a12 + r[4] + rol(t, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + r[7] + ss1 + w[j];
      r[3] = r[2];
      r[2] = rol(r[1], 9);
      r[1] = r[0];
      r[0] = tt1;
      r[7] = r[6];
      r[6] = rol(r[5], 19);
      r[5] = r[4];
      r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
    end
    foreach (chain[i]) chain[i] ^= r[i];
  endfunction

  function void add_byte(logic [7:0] b);
    blk[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
    pos = pos + 6'd1;
    if (pos == 0) compress();
  endfunction

  // note an accepted input transfer
  function void note_word(logic [31:0] word, logic [2:0] nb, logic fin);
    int n;
    logic [63:0] bits;
    n = (nb > 4) ? 4 : nb;
    for (int i = 0; i < n; i++) begin
      add_byte(word[31 - 8*i -: 8]);
      byte_cnt = byte_cnt + 64'd1;
    end
    if (!fin) return;
    bits = byte_cnt << 3;
    add_byte(sm3_pkg::PadByte);
    while (pos != 56) add_byte(8'h00);
    for (int i = 0; i < 8; i++) add_byte(bits[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      exp_word.push_back(chain[i]);
      exp_index.push_back(i[2:0]);
      exp_last.push_back(i == 7);
    end
    restart();
  endfunction

  // check one output transfer against the oldest expectation
  function void check_digest(logic [31:0] word, logic [2:0] idx, logic last);
    if (exp_word.size() == 0) begin
      $display("%0t: unexpected digest transfer word %h index %0d", $time, word, idx);
      errors++;
      return;
    end
    if (word !== exp_word[0]) begin
      $display("%0t: digest_word expected %h actual %h", $time, exp_word[0], word);
      errors++;
    end
    if (idx !== exp_index[0]) begin
      $display("%0t: digest_index expected %0d actual %0d", $time, exp_index[0], idx);
      errors++;
    end
    if (last !== exp_last[0]) begin
      $display("%0t: digest_last expected %0d actual %0d", $time, exp_last[0], last);
      errors++;
    end
    if (last === 1'b1) digests++;
    void'(exp_word.pop_front());
    void'(exp_index.pop_front());
    void'(exp_last.pop_front());
  endfunction
endclass

module testbench;

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_message_word;
  logic [2:0]  in_valid_bytes;
  logic        in_final_word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_digest_index;
  logic        out_digest_last;

  sm3_digest_board board;
  int cycles = 0;
  int words_sent;
  bit sink_enable;

  sm3_hash_engine uut (.*);

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("sm3_hash_engine verification failed");
      $finish;
    end
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random stalls, check each transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_digest(out_digest_word, out_digest_index, out_digest_last);
  end

  initial begin : sink
    int g;
    out_ready <= 1'b0;
    wait (sink_enable);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // one input transfer, with an optional idle gap ahead of it
  task automatic send_word(logic [31:0] word, logic [2:0] nb, logic fin, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_message_word <= word;
    in_valid_bytes <= nb;
    in_final_word <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(word, nb, fin);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.exp_word.size() != 0) @(posedge clk);
  endtask

  // message of n whole words with random content, last word possibly short
  task automatic send_message(int n, bit gaps);
    for (int i = 0; i < n; i++)
      send_word($urandom, (i == n - 1) ? 3'($urandom_range(0, 7)) : 3'd4,
                i == n - 1, gaps);
  endtask

  initial begin
    int len;
    board = new();
    words_sent = 0;
    sink_enable = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_message_word <= '0;
    in_valid_bytes <= '0;
    in_final_word <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sink_enable = 1;

    // directed: empty message, field extremes, short and oversized words
    send_word(32'h0, 3'd0, 1'b1, 1'b0);
    send_word(32'h6162_6300, 3'd3, 1'b1, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0);
    send_word(32'h0000_0000, 3'd0, 1'b0, 1'b0);
    send_word(32'hA5A5_A5A5, 3'd7, 1'b0, 1'b0);
    send_word(32'h1234_5678, 3'd1, 1'b0, 1'b0);
    send_word(32'h5A5A_5A5A, 3'd2, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd5, 1'b1, 1'b0);
    send_word(32'h0F0F_F0F0, 3'd6, 1'b1, 1'b0);
    // 52- to 56-byte message; at 56 bytes it forces a second padding block
    send_message(14, 1'b0);
    send_word(32'hDEAD_BEEF, 3'd4, 1'b1, 1'b0);
    wait_drained();

    // random messages, mostly short, a few spanning several blocks
    while (words_sent < 120) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0)
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'b1);
      send_message(len, 1'b1);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    wait_drained();
    repeat (200) @(posedge clk);

    $display("sent %0d words, %0d digests checked, incl. empty, short and two-pad messages",
             words_sent, board.digests);
    if (board.errors == 0 && board.exp_word.size() == 0) begin
      $display("sm3_hash_engine verification clean");
    end else begin
      $display("sm3_hash_engine verification failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/sm3_pkg.sv
rtl/sm3_core.sv
rtl/sm3_hash_engine.sv
rtl/sm3_checker.sv
sim/testbench.sv
